// ===== rtl/core/hqv_pkg.sv =====
// ----------------------------------------------------------------------------
// hqv_pkg
// Shared types, constants and helper functions for the hemisphere quad
// vertex generator.
// ----------------------------------------------------------------------------
package hqv_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_RADIUS      = 2'd0;
    localparam logic [1:0] REG_SLICE_COUNT = 2'd1;
    localparam logic [1:0] REG_STACK_COUNT = 2'd2;

    localparam logic [15:0] RADIUS_RST      = 16'd256;
    localparam logic [8:0]  SLICE_COUNT_RST = 9'd16;
    localparam logic [8:0]  STACK_COUNT_RST = 9'd8;

    // largest usable division count
    localparam logic [8:0] MAX_DIVISIONS = 9'd256;

    // CORDIC setup: x starts at the inverse gain scaled by 2^24
    localparam int              CORDIC_STEPS = 15;
    localparam logic signed [26:0] CORDIC_GAIN = 27'sd10188014;
    localparam logic signed [26:0] Q14_ONE_W   = 27'sd16384;

    // request as it travels from front to back
    typedef struct packed {
        logic [7:0] stack_idx;
        logic [7:0] slice_idx;
        logic       bad;
    } t_item;

    // arctangent of 2^-k in phase units (65536 per turn)
    function automatic logic signed [16:0] atan_of(input logic [3:0] k);
        logic signed [16:0] a;
        case (k)
            4'd0:    a = 17'sd8192;
            4'd1:    a = 17'sd4836;
            4'd2:    a = 17'sd2555;
            4'd3:    a = 17'sd1297;
            4'd4:    a = 17'sd651;
            4'd5:    a = 17'sd326;
            4'd6:    a = 17'sd163;
            4'd7:    a = 17'sd81;
            4'd8:    a = 17'sd41;
            4'd9:    a = 17'sd20;
            4'd10:   a = 17'sd10;
            4'd11:   a = 17'sd5;
            4'd12:   a = 17'sd3;
            4'd13:   a = 17'sd1;
            4'd14:   a = 17'sd1;
            default: a = 17'sd0;
        endcase
        return a;
    endfunction

    // corner code of vertex v: triangles use corners 0,1,2 and 1,3,2
    function automatic logic [1:0] corner_of(input logic [2:0] v);
        logic [1:0] c;
        case (v)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd1;
            3'd4:    c = 2'd3;
            default: c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/hqv_front.sv =====
// ----------------------------------------------------------------------------
// hqv_front
// Accepts quad requests, flags out-of-range indexes and queues them for
// the vertex engine.
// ----------------------------------------------------------------------------
module hqv_front
    import hqv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_stack_index,
    input  logic [7:0] i_slice_index,
    input  logic [8:0] i_stack_cnt,
    input  logic [8:0] i_slice_cnt,
    output logic       o_q_valid,
    output t_item      o_q_item,
    input  logic       i_q_pop
);

    t_item       r_mem [4];
    logic [1:0]  r_wp;
    logic [1:0]  r_rp;
    logic [2:0]  r_cnt;
    logic        push;
    logic        pop;
    t_item       item;

    // classify the incoming request
    always_comb begin
        item.stack_idx = i_stack_index;
        item.slice_idx = i_slice_index;
        item.bad       = ({1'b0, i_stack_index} >= i_stack_cnt) ||
                         ({1'b0, i_slice_index} >= i_slice_cnt);
    end

    assign o_stall   = (r_cnt == 3'd4);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 3'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rp];

    // store queued requests
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= item;
        end
    end

    // advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 3'd1;
                2'b01:   r_cnt <= r_cnt - 3'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/hqv_back.sv =====
// ----------------------------------------------------------------------------
// hqv_back
// Vertex engine: divides out the four phases, runs a shared CORDIC over
// them, then builds and sends the quad's six vertices, or one flagged result.
// ----------------------------------------------------------------------------
module hqv_back
    import hqv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_item              i_q_item,
    output logic               o_q_pop,
    input  logic [15:0]        i_radius,
    input  logic [8:0]         i_stack_cnt,
    input  logic [8:0]         i_slice_cnt,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [16:0] o_pos_x,
    output logic signed [16:0] o_pos_y,
    output logic signed [16:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic [1:0]         o_corner,
    output logic               o_last,
    output logic               o_bad_index
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_CINIT = 4'd3;
    localparam logic [3:0] S_CORD  = 4'd4;
    localparam logic [3:0] S_NRM   = 4'd5;
    localparam logic [3:0] S_POS   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_BAD   = 4'd8;

    logic [3:0]         r_state;
    logic [7:0]         r_i;
    logic [7:0]         r_j;
    logic [8:0]         r_ns;
    logic [8:0]         r_nl;
    logic [4:0]         r_k;
    logic [1:0]         r_sel;
    logic [9:0]         r_rem;
    logic [24:0]        r_quo;
    logic [15:0]        r_ph  [4];
    logic signed [26:0] r_x;
    logic signed [26:0] r_y;
    logic signed [16:0] r_z;
    logic signed [15:0] r_cos [4];
    logic signed [15:0] r_sin [4];
    logic [2:0]         r_v;
    logic [1:0]         r_ax;
    logic signed [15:0] r_n0;
    logic signed [15:0] r_n1;
    logic signed [15:0] r_n2;
    logic signed [16:0] r_px;
    logic signed [16:0] r_py;
    logic signed [16:0] r_pz;

    logic               r_ovalid;
    logic signed [16:0] r_opx;
    logic signed [16:0] r_opy;
    logic signed [16:0] r_opz;
    logic signed [15:0] r_onx;
    logic signed [15:0] r_ony;
    logic signed [15:0] r_onz;
    logic [1:0]         r_ocorner;
    logic               r_olast;
    logic               r_obad;

    logic               out_free;
    logic [24:0]        num;
    logic [8:0]         ip1;
    logic [8:0]         jp1;
    logic [8:0]         dvsr;
    logic [9:0]         rem_sh;
    logic               ge;
    logic [24:0]        quo_n;
    logic signed [26:0] dx;
    logic signed [26:0] dy;
    logic signed [26:0] xr;
    logic signed [26:0] yr;
    logic signed [15:0] cr;
    logic signed [15:0] sr;
    logic signed [15:0] cq;
    logic signed [15:0] sq;
    logic [1:0]         quad;
    logic [1:0]         corner;
    logic [1:0]         st_sel;
    logic [1:0]         sl_sel;
    logic signed [31:0] p0;
    logic signed [31:0] p2;
    logic signed [31:0] p0r;
    logic signed [31:0] p2r;
    logic signed [15:0] nsel;
    logic signed [32:0] pp;
    logic signed [32:0] ppr;

    assign out_free = !r_ovalid || !i_stall;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    // numerator of the current phase division
    always_comb begin
        ip1 = {1'b0, r_i} + 9'd1;
        jp1 = {1'b0, r_j} + 9'd1;
        case (r_sel)
            2'd0:    num = {3'b0, r_i, 14'b0} + {17'b0, r_ns[8:1]};
            2'd1:    num = {2'b0, ip1, 14'b0} + {17'b0, r_ns[8:1]};
            2'd2:    num = {1'b0, r_j, 16'b0} + {17'b0, r_nl[8:1]};
            default: num = {jp1, 16'b0} + {17'b0, r_nl[8:1]};
        endcase
    end

    // one restoring division step
    always_comb begin
        dvsr   = r_sel[1] ? r_nl : r_ns;
        rem_sh = {r_rem[8:0], r_quo[24]};
        ge     = (rem_sh >= {1'b0, dvsr});
        quo_n  = {r_quo[23:0], ge};
    end

    // CORDIC step and final rounding into the right quadrant
    always_comb begin
        dx   = r_y >>> r_k[3:0];
        dy   = r_x >>> r_k[3:0];
        xr   = (r_x + 27'sd512) >>> 10;
        yr   = (r_y + 27'sd512) >>> 10;
        if (xr > Q14_ONE_W) begin
            cr = 16'sd16384;
        end else if (xr < -Q14_ONE_W) begin
            cr = -16'sd16384;
        end else begin
            cr = xr[15:0];
        end
        if (yr > Q14_ONE_W) begin
            sr = 16'sd16384;
        end else if (yr < -Q14_ONE_W) begin
            sr = -16'sd16384;
        end else begin
            sr = yr[15:0];
        end
        quad = r_ph[r_sel][15:14];
        case (quad)
            2'd0:    begin cq = cr;  sq = sr;  end
            2'd1:    begin cq = -sr; sq = cr;  end
            2'd2:    begin cq = -cr; sq = -sr; end
            default: begin cq = sr;  sq = -cr; end
        endcase
    end

    // normal of the current vertex
    always_comb begin
        corner = corner_of(r_v);
        st_sel = (corner < 2'd2) ? 2'd1 : 2'd0;
        sl_sel = corner[0] ? 2'd3 : 2'd2;
        p0     = r_cos[sl_sel] * r_cos[st_sel];
        p2     = r_sin[sl_sel] * r_cos[st_sel];
        p0r    = (p0 + 32'sd8192) >>> 14;
        p2r    = (p2 + 32'sd8192) >>> 14;
    end

    // position, one axis a cycle
    always_comb begin
        case (r_ax)
            2'd0:    nsel = r_n0;
            2'd1:    nsel = r_n1;
            default: nsel = r_n2;
        endcase
        pp  = $signed({1'b0, i_radius}) * nsel;
        ppr = (pp + 33'sd8192) >>> 14;
    end

    // sequence one request through divide, CORDIC and vertex build
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_i   <= i_q_item.stack_idx;
                        r_j   <= i_q_item.slice_idx;
                        r_ns  <= i_stack_cnt;
                        r_nl  <= i_slice_cnt;
                        r_sel <= 2'd0;
                        r_state <= i_q_item.bad ? S_BAD : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_quo   <= num;
                    r_rem   <= 10'd0;
                    r_k     <= 5'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_quo <= quo_n;
                    r_rem <= ge ? (rem_sh - {1'b0, dvsr}) : rem_sh;
                    r_k   <= r_k + 5'd1;
                    if (r_k == 5'd24) begin
                        r_ph[r_sel] <= quo_n[15:0];
                        r_sel       <= r_sel + 2'd1;
                        r_state     <= (r_sel == 2'd3) ? S_CINIT : S_LOAD;
                    end
                end
                S_CINIT: begin
                    r_x     <= CORDIC_GAIN;
                    r_y     <= 27'sd0;
                    r_z     <= {3'b0, r_ph[r_sel][13:0]};
                    r_k     <= 5'd0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (r_k == 5'(CORDIC_STEPS)) begin
                        r_cos[r_sel] <= cq;
                        r_sin[r_sel] <= sq;
                        r_sel        <= r_sel + 2'd1;
                        r_v          <= 3'd0;
                        r_state      <= (r_sel == 2'd3) ? S_NRM : S_CINIT;
                    end else begin
                        if (!r_z[16]) begin
                            r_x <= r_x - dx;
                            r_y <= r_y + dy;
                            r_z <= r_z - atan_of(r_k[3:0]);
                        end else begin
                            r_x <= r_x + dx;
                            r_y <= r_y - dy;
                            r_z <= r_z + atan_of(r_k[3:0]);
                        end
                        r_k <= r_k + 5'd1;
                    end
                end
                S_NRM: begin
                    r_n0    <= p0r[15:0];
                    r_n1    <= r_sin[st_sel];
                    r_n2    <= p2r[15:0];
                    r_ax    <= 2'd0;
                    r_state <= S_POS;
                end
                S_POS: begin
                    case (r_ax)
                        2'd0:    r_px <= ppr[16:0];
                        2'd1:    r_py <= ppr[16:0];
                        default: r_pz <= ppr[16:0];
                    endcase
                    r_ax <= r_ax + 2'd1;
                    if (r_ax == 2'd2) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_v     <= r_v + 3'd1;
                        r_state <= (r_v == 3'd5) ? S_IDLE : S_NRM;
                    end
                end
                S_BAD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // hold the result until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_OUT || r_state == S_BAD) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // load result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_opx     <= r_px;
            r_opy     <= r_py;
            r_opz     <= r_pz;
            r_onx     <= r_n0;
            r_ony     <= r_n1;
            r_onz     <= r_n2;
            r_ocorner <= corner;
            r_olast   <= (r_v == 3'd5);
            r_obad    <= 1'b0;
        end else if (r_state == S_BAD && out_free) begin
            r_opx     <= 17'sd0;
            r_opy     <= 17'sd0;
            r_opz     <= 17'sd0;
            r_onx     <= 16'sd0;
            r_ony     <= 16'sd0;
            r_onz     <= 16'sd0;
            r_ocorner <= 2'd0;
            r_olast   <= 1'b1;
            r_obad    <= 1'b1;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_pos_x     = r_opx;
    assign o_pos_y     = r_opy;
    assign o_pos_z     = r_opz;
    assign o_norm_x    = r_onx;
    assign o_norm_y    = r_ony;
    assign o_norm_z    = r_onz;
    assign o_corner    = r_ocorner;
    assign o_last      = r_olast;
    assign o_bad_index = r_obad;

endmodule

// ===== rtl/core/hemisphere_quad_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// hemisphere_quad_vertex_generator
// Emits the six vertices (position and unit normal) of one hemisphere quad.
// ----------------------------------------------------------------------------
// A request (stack, slice) is queued by the front end, up to four deep, so
// new requests keep being taken while the engine works. A valid request is
// taken from the queue, then put through four phase divisions in one
// bit-serial divider and four sine/cosine evaluations in one iterative
// CORDIC; then for each vertex the engine forms the normal and the three
// position products, which share one multiplier, and sends the vertex.
// A request with an index at or beyond its count gives a single flagged
// result. Results leave through an output register; stall on the result
// channel holds the engine. Counts above 256 are used as 256.
module hemisphere_quad_vertex_generator
    import hqv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_stack_index,
    input  logic [7:0]         i_slice_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [16:0] o_pos_x,
    output logic signed [16:0] o_pos_y,
    output logic signed [16:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic [1:0]         o_corner,
    output logic               o_last,
    output logic               o_bad_index
);

    logic [15:0] r_radius;
    logic [8:0]  r_slice_cnt;
    logic [8:0]  r_stack_cnt;
    logic [8:0]  stack_eff;
    logic [8:0]  slice_eff;
    logic        q_valid;
    logic        q_pop;
    t_item       q_item;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RADIUS_RST;
            r_slice_cnt <= SLICE_COUNT_RST;
            r_stack_cnt <= STACK_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIUS:      r_radius    <= i_cfg_data;
                REG_SLICE_COUNT: r_slice_cnt <= i_cfg_data[8:0];
                REG_STACK_COUNT: r_stack_cnt <= i_cfg_data[8:0];
                default:         ;
            endcase
        end
    end

    // limit counts to the largest division count
    assign stack_eff = (r_stack_cnt > MAX_DIVISIONS) ? MAX_DIVISIONS : r_stack_cnt;
    assign slice_eff = (r_slice_cnt > MAX_DIVISIONS) ? MAX_DIVISIONS : r_slice_cnt;

    hqv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_stack_index (i_stack_index),
        .i_slice_index (i_slice_index),
        .i_stack_cnt   (stack_eff),
        .i_slice_cnt   (slice_eff),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    hqv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .i_radius    (r_radius),
        .i_stack_cnt (stack_eff),
        .i_slice_cnt (slice_eff),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .o_norm_x    (o_norm_x),
        .o_norm_y    (o_norm_y),
        .o_norm_z    (o_norm_z),
        .o_corner    (o_corner),
        .o_last      (o_last),
        .o_bad_index (o_bad_index)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hemisphere quad vertex generator: directed and
// random quad requests under several radius and count settings and several
// idle/stall mixes, each vertex compared against an internal predictor.
// ----------------------------------------------------------------------------
module tb
    import hqv_pkg::*;
();

    // register index with no register behind it
    localparam logic [1:0] REG_UNKNOWN = 2'd3;

    typedef struct {
        logic signed [16:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
        logic [1:0]         corner;
        logic               last;
        logic               bad;
    } t_vertex;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_stack_index;
    logic [7:0]         i_slice_index;
    logic               o_valid;
    logic               i_stall;
    logic signed [16:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [15:0] o_norm_x, o_norm_y, o_norm_z;
    logic [1:0]         o_corner;
    logic               o_last;
    logic               o_bad_index;

    hemisphere_quad_vertex_generator DUT (.*);

    // predictor copy of the registers
    int unsigned cur_radius;
    int unsigned cur_slices;
    int unsigned cur_stacks;

    t_vertex     vertex_q[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          atan_tbl[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
                                  10, 5, 3, 1, 1};

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    // cosine and sine of a 16-bit phase in Q1.14
    function automatic void phase_trig(input int unsigned ph, output longint c,
                                       output longint s);
        longint x, y, z, dx, dy, cr, sr;
        x = 10188014;
        y = 0;
        z = ph & 16'h3FFF;
        for (int k = 0; k < 15; k++) begin
            dx = floor_shift(y, k);
            dy = floor_shift(x, k);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tbl[k];
            end else begin
                x += dx; y -= dy; z += atan_tbl[k];
            end
        end
        cr = clamp_unit(floor_shift(x + 512, 10));
        sr = clamp_unit(floor_shift(y + 512, 10));
        case ((ph >> 14) & 3)
            0: begin c = cr;  s = sr;  end
            1: begin c = -sr; s = cr;  end
            2: begin c = -cr; s = -sr; end
            default: begin c = sr; s = -cr; end
        endcase
    endfunction

    function automatic t_vertex quad_vertex(int unsigned st_ph, int unsigned sl_ph,
                                            logic [1:0] corner, logic last);
        t_vertex v;
        longint cst, sst, csl, ssl, n0, n1, n2;
        phase_trig(st_ph, cst, sst);
        phase_trig(sl_ph, csl, ssl);
        n0 = floor_shift(csl * cst + 8192, 14);
        n1 = sst;
        n2 = floor_shift(ssl * cst + 8192, 14);
        v.nx = n0[15:0];
        v.ny = n1[15:0];
        v.nz = n2[15:0];
        n0 = floor_shift(longint'(cur_radius) * n0 + 8192, 14);
        n1 = floor_shift(longint'(cur_radius) * n1 + 8192, 14);
        n2 = floor_shift(longint'(cur_radius) * n2 + 8192, 14);
        v.px = n0[16:0];
        v.py = n1[16:0];
        v.pz = n2[16:0];
        v.corner = corner;
        v.last = last;
        v.bad = 1'b0;
        return v;
    endfunction

    // append one expected vertex
    function automatic void queue_vertex(input t_vertex v);
        vertex_q = {vertex_q, v};
    endfunction

    // queue the expected vertices of one quad request
    task automatic predict_quad(input logic [7:0] si, input logic [7:0] sj);
        longint unsigned ns, nl, i, j;
        int unsigned st0, st1, sl0, sl1, st, sl;
        t_vertex v;
        logic [1:0] c;
        ns = (cur_stacks > 256) ? 256 : cur_stacks;
        nl = (cur_slices > 256) ? 256 : cur_slices;
        i = si;
        j = sj;
        if (i >= ns || j >= nl) begin
            v = '{default: 0};
            v.last = 1'b1;
            v.bad = 1'b1;
            queue_vertex(v);
        end else begin
            st0 = 32'((i * 16384 + ns / 2) / ns);
            st1 = 32'(((i + 1) * 16384 + ns / 2) / ns);
            sl0 = 32'(((j * 65536 + nl / 2) / nl) & 16'hFFFF);
            sl1 = 32'((((j + 1) * 65536 + nl / 2) / nl) & 16'hFFFF);
            for (int r = 0; r < 6; r++) begin
                c = corner_of(3'(r));
                st = (c < 2) ? st1 : st0;
                sl = (c[0] == 1'b0) ? sl0 : sl1;
                queue_vertex(quad_vertex(st, sl, c, r == 5));
            end
        end
    endtask

    // send one request, idling first at the configured rate
    task automatic send_quad(input logic [7:0] si, input logic [7:0] sj);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_stack_index <= si;
        i_slice_index <= sj;
        predict_quad(si, sj);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drop valid and wait until every expected vertex has arrived
    task automatic drain_wait();
        i_valid <= 1'b0;
        while (vertex_q.size() != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_RADIUS:      cur_radius = data;
            REG_SLICE_COUNT: cur_slices = data[8:0];
            REG_STACK_COUNT: cur_stacks = data[8:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(input int unsigned rad, input int unsigned sl,
                              input int unsigned st);
        drain_wait();
        write_reg(REG_RADIUS, 16'(rad));
        write_reg(REG_SLICE_COUNT, 16'(sl));
        write_reg(REG_STACK_COUNT, 16'(st));
    endtask

    // random stall on the result side, set on the falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // compare each vertex transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (vertex_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected vertex at %0t", $time);
            end else begin
                e = vertex_q.pop_front();
                if (o_pos_x !== e.px || o_pos_y !== e.py || o_pos_z !== e.pz ||
                    o_norm_x !== e.nx || o_norm_y !== e.ny || o_norm_z !== e.nz ||
                    o_corner !== e.corner || o_last !== e.last ||
                    o_bad_index !== e.bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch at %0t: ", $time,
                                 "exp p=%0d,%0d,%0d n=%0d,%0d,%0d c=%0d l=%0b b=%0b ",
                                 e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.corner,
                                 e.last, e.bad,
                                 "got p=%0d,%0d,%0d n=%0d,%0d,%0d c=%0d l=%0b b=%0b",
                                 o_pos_x, o_pos_y, o_pos_z, o_norm_x,
                                 o_norm_y, o_norm_z, o_corner, o_last, o_bad_index);
                end
            end
        end
    end

    task automatic test_directed();
        set_config(256, 16, 8);
        send_quad(0, 0);
        send_quad(7, 15);
        send_quad(8, 0);
        send_quad(0, 16);
        send_quad(255, 255);
        send_quad(3, 5);
        // zero radius
        set_config(0, 4, 4);
        send_quad(1, 2);
        send_quad(3, 3);
        // largest radius, single division
        set_config(65535, 1, 1);
        send_quad(0, 0);
        send_quad(1, 0);
        // counts beyond the usable limit
        set_config(1, 511, 511);
        send_quad(255, 255);
        send_quad(0, 128);
        // zero counts
        set_config(300, 0, 0);
        send_quad(0, 0);
        // unknown register is ignored
        drain_wait();
        write_reg(REG_UNKNOWN, 16'hFFFF);
        send_quad(0, 0);
    endtask

    task automatic test_random_phase(input int n, input int idle, input int stall);
        int unsigned sl, st;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        sl = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(1, 24);
        st = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(1, 24);
        set_config($urandom_range(65535), sl, st);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) < 8)
                send_quad(8'($urandom_range(st == 0 ? 0 : (st > 256 ? 255 : st - 1))),
                          8'($urandom_range(sl == 0 ? 0 : (sl > 256 ? 255 : sl - 1))));
            else
                send_quad(8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_random();
        test_random_phase(60, 0, 0);
        test_random_phase(70, 52, 0);
        test_random_phase(70, 0, 52);
        test_random_phase(70, 11, 11);
        // pause until everything has drained, then resume
        drain_wait();
        test_random_phase(60, 0, 0);
        test_random_phase(60, 52, 52);
        test_random_phase(60, 11, 11);
    endtask

    initial begin
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cur_radius = 256;
        cur_slices = 16;
        cur_stacks = 8;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_stack_index = '0;
        i_slice_index = '0;
        i_stall = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random();
        drain_wait();
        recv_stall_pct = 0;
        if (mismatches == 0 && vertex_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== hemisphere_quad_vertex_generator.f =====
rtl/core/hqv_pkg.sv
rtl/core/hqv_front.sv
rtl/core/hqv_back.sv
rtl/core/hemisphere_quad_vertex_generator.sv
dv/tb.sv
